// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the sorted queue block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPQB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/spqb_pkg.sv
// ----------------------------------------------------------------------------
// spqb_pkg
// Request kinds, status codes and fixed field widths of the sorted queue.
// ----------------------------------------------------------------------------
package spqb_pkg;

    localparam int TAG_W        = 16;
    localparam int OUT_WEIGHT_W = 32;
    localparam int OUT_COUNT_W  = 7;

    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_BFIRST = 2'd2;
    localparam logic [1:0] REQ_BNEXT  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [TAG_W-1:0] t_tag;

endpackage

// File: hw/rtl/spqb_if.sv
// ----------------------------------------------------------------------------
// spqb_req_if / spqb_rsp_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface spqb_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    spqb_pkg::t_tag    parent_value;
    spqb_pkg::t_tag    slot_index;
    logic [31:0]       path_weight;

    modport source (output valid, output req_type, output parent_value,
                    output slot_index, output path_weight, input ready);
    modport sink   (input valid, input req_type, input parent_value,
                    input slot_index, input path_weight, output ready);
endinterface

interface spqb_rsp_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    spqb_pkg::t_tag    out_parent;
    spqb_pkg::t_tag    out_index;
    logic [31:0]       out_weight;
    logic              queue_empty;
    logic              browse_done;
    logic              single_entry;
    logic [6:0]        entry_count;

    modport source (output valid, output status, output out_parent, output out_index,
                    output out_weight, output queue_empty, output browse_done,
                    output single_entry, output entry_count, input ready);
    modport sink   (input valid, input status, input out_parent, input out_index,
                    input out_weight, input queue_empty, input browse_done,
                    input single_entry, input entry_count, output ready);
endinterface

// File: hw/rtl/spqb_store.sv
// ----------------------------------------------------------------------------
// spqb_store
// Entry memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spqb_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 64
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/spqb_addr.sv
// ----------------------------------------------------------------------------
// spqb_addr
// Shared address unit: maps a rank from the head to a slot of the ring.
// ----------------------------------------------------------------------------
module spqb_addr #(
    parameter int CAPACITY = 64,
    parameter int AW       = 6,
    parameter int CW       = 7
) (
    input  logic [AW-1:0] i_head,
    input  logic [CW-1:0] i_lidx,
    output logic [AW-1:0] o_phys
);

    localparam int SW = CW + 1;

    logic [SW-1:0] s_sum;
    logic [SW-1:0] s_wrap;

    always_comb begin
        s_sum  = SW'(i_head) + SW'(i_lidx);
        s_wrap = s_sum;
        if (s_sum >= SW'(CAPACITY)) begin
            s_wrap = s_sum - SW'(CAPACITY);
        end
    end

    assign o_phys = AW'(s_wrap);

endmodule

// File: hw/rtl/sorted_priority_queue_with_browse.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_with_browse
// Sorted priority queue with a non-destructive browse cursor.
// ----------------------------------------------------------------------------
// Entries are kept in ascending weight order in a ring held in one memory
// with one write and one registered read port; a pop just advances the head.
// One request word is taken at a time and gives one result word. A push
// reads each stored entry whose weight is equal to or above the new one
// and moves it up one slot through the single memory port pair, from the
// tail down, then writes the new entry. When every stored entry moves, an
// empty queue included, the scan ends without a final compare. A pop or
// browse read passes a read state and a read-wait state, and a dropped
// push or a read with nothing to read goes straight to the result state.
// The next request is taken once the result has entered the output
// register. The cursor is kept as the number of entries left to browse.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_priority_queue_with_browse #(
    parameter int CAPACITY    = 64,
    parameter int WEIGHT_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spqb_req_if.sink   i_req,
    spqb_rsp_if.source o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = 2 * spqb_pkg::TAG_W + WEIGHT_BITS;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_READ     = 3'd1;
    localparam logic [2:0] S_READ_W   = 3'd2;
    localparam logic [2:0] S_SCAN_RD  = 3'd3;
    localparam logic [2:0] S_SCAN_CMP = 3'd4;
    localparam logic [2:0] S_INSERT   = 3'd5;
    localparam logic [2:0] S_RESULT   = 3'd6;

    logic [2:0]             r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_rank, n_rank;
    logic [AW-1:0]          r_head, n_head;
    logic [CW-1:0]          r_pos, n_pos;
    logic [1:0]             r_status, n_status;

    logic [1:0]             r_req;
    spqb_pkg::t_tag         r_parent;
    spqb_pkg::t_tag         r_index;
    logic [WEIGHT_BITS-1:0] r_weight;
    spqb_pkg::t_tag         r_rd_parent;
    spqb_pkg::t_tag         r_rd_index;
    logic [WEIGHT_BITS-1:0] r_rd_weight;

    logic                   r_ov;
    logic [1:0]             r_o_status;
    spqb_pkg::t_tag         r_o_parent;
    spqb_pkg::t_tag         r_o_index;
    logic [31:0]            r_o_weight;
    logic                   r_o_empty;
    logic                   r_o_done;
    logic                   r_o_single;
    logic [6:0]             r_o_count;

    logic                   s_acc;
    logic                   s_out_free;
    logic [CW-1:0]          s_eff;
    logic [CW-1:0]          s_lidx;
    logic [AW-1:0]          s_phys;
    logic                   s_we;
    logic [DW-1:0]          s_wdata;
    logic [DW-1:0]          s_rdata;
    spqb_pkg::t_tag         s_rd_parent;
    spqb_pkg::t_tag         s_rd_index;
    logic [WEIGHT_BITS-1:0] s_rd_weight;

    assign s_acc      = i_req.valid && (r_state == S_IDLE);
    assign s_out_free = !r_ov || o_rsp.ready;
    assign {s_rd_parent, s_rd_index, s_rd_weight} = s_rdata;

    spqb_addr #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_addr (
        .i_head (r_head),
        .i_lidx (s_lidx),
        .o_phys (s_phys)
    );

    spqb_store #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (DW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_phys),
        .i_wdata (s_wdata),
        .i_raddr (s_phys),
        .o_rdata (s_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_rank   = r_rank;
        n_head   = r_head;
        n_pos    = r_pos;
        n_status = r_status;
        s_lidx   = r_pos;
        s_we     = 1'b0;
        s_wdata  = {r_parent, r_index, r_weight};
        s_eff    = (i_req.req_type == spqb_pkg::REQ_BFIRST) ? r_count : r_rank;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_status = spqb_pkg::ST_OK;
                    unique case (i_req.req_type)
                        spqb_pkg::REQ_PUSH: begin
                            if (r_count == CAP_C) begin
                                n_status = spqb_pkg::ST_FULL;
                                n_state  = S_RESULT;
                            end else if (r_count == '0) begin
                                n_pos   = '0;
                                n_state = S_INSERT;
                            end else begin
                                n_pos   = r_count;
                                n_state = S_SCAN_RD;
                            end
                        end
                        spqb_pkg::REQ_POP: begin
                            if (r_count == '0) begin
                                n_status = spqb_pkg::ST_EMPTY;
                                n_state  = S_RESULT;
                            end else begin
                                n_pos   = '0;
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            if (s_eff == '0 || s_eff > r_count) begin
                                n_rank   = '0;
                                n_status = spqb_pkg::ST_EMPTY;
                                n_state  = S_RESULT;
                            end else begin
                                n_pos   = r_count - s_eff;
                                n_rank  = s_eff - CW'(1);
                                n_state = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_READ_W;
            end
            S_READ_W: begin
                if (r_req == spqb_pkg::REQ_POP) begin
                    // The address unit gives the slot after the head here.
                    s_lidx  = CW'(1);
                    n_head  = s_phys;
                    n_count = r_count - CW'(1);
                    if (r_rank == r_count) begin
                        n_rank = r_rank - CW'(1);
                    end
                end
                n_state = S_RESULT;
            end
            S_SCAN_RD: begin
                s_lidx  = r_pos - CW'(1);
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                // Entries of equal or higher weight move up to make room.
                if (s_rd_weight >= r_weight) begin
                    s_we    = 1'b1;
                    s_wdata = s_rdata;
                    n_pos   = r_pos - CW'(1);
                    n_state = (r_pos == CW'(1)) ? S_INSERT : S_SCAN_RD;
                end else begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: begin
                s_we    = 1'b1;
                n_count = r_count + CW'(1);
                if (r_rank != '0 && r_pos > (r_count - r_rank)) begin
                    n_rank = r_rank + CW'(1);
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (s_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rank  <= '0;
            r_head  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rank  <= n_rank;
            r_head  <= n_head;
            if (r_state == S_RESULT && s_out_free) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_status <= n_status;
        if (s_acc) begin
            r_req       <= i_req.req_type;
            r_parent    <= i_req.parent_value;
            r_index     <= i_req.slot_index;
            r_weight    <= WEIGHT_BITS'(i_req.path_weight);
            r_rd_parent <= '0;
            r_rd_index  <= '0;
            r_rd_weight <= '0;
        end else if (r_state == S_READ_W) begin
            r_rd_parent <= s_rd_parent;
            r_rd_index  <= s_rd_index;
            r_rd_weight <= s_rd_weight;
        end
        if (r_state == S_RESULT && s_out_free) begin
            r_o_status <= r_status;
            r_o_parent <= r_rd_parent;
            r_o_index  <= r_rd_index;
            r_o_weight <= spqb_pkg::OUT_WEIGHT_W'(r_rd_weight);
            r_o_empty  <= (r_count == '0);
            r_o_done   <= (r_rank == '0);
            r_o_single <= (r_count == CW'(1));
            r_o_count  <= spqb_pkg::OUT_COUNT_W'(r_count);
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.out_parent   = r_o_parent;
    assign o_rsp.out_index    = r_o_index;
    assign o_rsp.out_weight   = r_o_weight;
    assign o_rsp.queue_empty  = r_o_empty;
    assign o_rsp.browse_done  = r_o_done;
    assign o_rsp.single_entry = r_o_single;
    assign o_rsp.entry_count  = r_o_count;

    `SPQB_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CAP_C, "count above capacity")
    `SPQB_ASSERT_NOW(a_rank_le_count, i_clk, i_rst_n, 1'b1, r_rank <= r_count, "cursor past count")
    `SPQB_ASSERT_NOW(a_write_range, i_clk, i_rst_n, s_we, s_lidx <= r_count, "write past tail")
    `SPQB_ASSERT_NEXT(a_busy_after_acc, i_clk, i_rst_n, s_acc, r_state != S_IDLE, "idle after accept")

endmodule

// File: tb/sv/sorted_priority_queue_with_browse_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_with_browse_tb
// Self-checking bench for the sorted priority queue with a browse cursor.
// A driver sends request words from a pending list in bursts, and a monitor
// checks every result word, field by field, against a behavioral copy of
// the queue kept inside the bench. The stimulus opens with hand-picked
// corner cases. Random episodes follow: fills to full, drains to empty,
// cursor walks with pushes and pops mixed in, and random request mixes.
// The receiver stalls on its own pattern and once holds off for a long time.
// ----------------------------------------------------------------------------
module sorted_priority_queue_with_browse_tb;

    localparam int QUEUE_DEPTH   = 64;
    localparam int RANDOM_ITEMS  = 1050;
    localparam int DRAIN_CYCLES  = 200;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [1:0]     kind;
        spqb_pkg::t_tag parent;
        spqb_pkg::t_tag index;
        logic [31:0]    weight;
    } t_request;

    typedef struct packed {
        logic [1:0]     status;
        spqb_pkg::t_tag parent;
        spqb_pkg::t_tag index;
        logic [31:0]    weight;
        logic           is_empty;
        logic           at_end;
        logic           single;
        logic [6:0]     count;
    } t_queue_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    spqb_req_if req_if ();
    spqb_rsp_if rsp_if ();

    sorted_priority_queue_with_browse #(
        .CAPACITY    (QUEUE_DEPTH),
        .WEIGHT_BITS (32)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Behavioral copy of the sorted store and the browse cursor.
    spqb_pkg::t_tag slot_parent [QUEUE_DEPTH];
    spqb_pkg::t_tag slot_index  [QUEUE_DEPTH];
    logic [31:0]    slot_weight [QUEUE_DEPTH];
    int             depth_now   = 0;
    int             cursor_left = 0;

    t_request      pending_reqs[$];
    t_queue_result expected_results[$];
    t_queue_result want;

    int error_count    = 0;
    int accepted_count = 0;
    int checked_count  = 0;
    int n_stored       = 0;
    int n_full_drops   = 0;
    int n_reads        = 0;
    int n_empty_reads  = 0;
    int peak_depth     = 0;
    int gen_depth      = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int rx_cycle       = 0;
    int rx_mode        = 0;
    logic long_hold;

    function automatic t_queue_result apply_request(input t_request rq);
        t_queue_result res;
        int pos;
        int cur_pos;
        res = '0;
        res.status = spqb_pkg::ST_OK;
        case (rq.kind)
            spqb_pkg::REQ_PUSH: begin
                if (depth_now >= QUEUE_DEPTH) begin
                    res.status = spqb_pkg::ST_FULL;
                    n_full_drops++;
                end else begin
                    pos = 0;
                    cur_pos = depth_now - cursor_left;
                    // Strict compare puts a new word ahead of equal weights.
                    while (pos < depth_now && slot_weight[pos] < rq.weight)
                        pos++;
                    for (int j = depth_now; j > pos; j--) begin
                        slot_parent[j] = slot_parent[j-1];
                        slot_index[j]  = slot_index[j-1];
                        slot_weight[j] = slot_weight[j-1];
                    end
                    slot_parent[pos] = rq.parent;
                    slot_index[pos]  = rq.index;
                    slot_weight[pos] = rq.weight;
                    if (cursor_left > 0 && pos > cur_pos)
                        cursor_left++;
                    depth_now++;
                    n_stored++;
                    if (depth_now > peak_depth)
                        peak_depth = depth_now;
                end
            end
            spqb_pkg::REQ_POP: begin
                if (depth_now == 0) begin
                    res.status = spqb_pkg::ST_EMPTY;
                    n_empty_reads++;
                end else begin
                    res.parent = slot_parent[0];
                    res.index  = slot_index[0];
                    res.weight = slot_weight[0];
                    // A cursor on the head slides onto the new head.
                    if (cursor_left == depth_now)
                        cursor_left--;
                    depth_now--;
                    for (int j = 0; j < depth_now; j++) begin
                        slot_parent[j] = slot_parent[j+1];
                        slot_index[j]  = slot_index[j+1];
                        slot_weight[j] = slot_weight[j+1];
                    end
                    n_reads++;
                end
            end
            default: begin
                if (rq.kind == spqb_pkg::REQ_BFIRST)
                    cursor_left = depth_now;
                if (cursor_left == 0 || cursor_left > depth_now) begin
                    cursor_left = 0;
                    res.status = spqb_pkg::ST_EMPTY;
                    n_empty_reads++;
                end else begin
                    res.parent = slot_parent[depth_now - cursor_left];
                    res.index  = slot_index[depth_now - cursor_left];
                    res.weight = slot_weight[depth_now - cursor_left];
                    cursor_left--;
                    n_reads++;
                end
            end
        endcase
        res.is_empty = (depth_now == 0);
        res.at_end   = (cursor_left == 0);
        res.single   = (depth_now == 1);
        res.count    = depth_now[6:0];
        return res;
    endfunction

    task automatic add_req(input logic [1:0] kind, input spqb_pkg::t_tag parent,
                           input spqb_pkg::t_tag index, input logic [31:0] weight);
        t_request rq;
        rq.kind   = kind;
        rq.parent = parent;
        rq.index  = index;
        rq.weight = weight;
        pending_reqs.push_back(rq);
        if (kind == spqb_pkg::REQ_PUSH && gen_depth < QUEUE_DEPTH)
            gen_depth++;
        else if (kind == spqb_pkg::REQ_POP && gen_depth > 0)
            gen_depth--;
    endtask

    // Weights cluster on a few small values so that ties are common.
    function automatic logic [31:0] pick_weight();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return 32'($urandom_range(0, 7));
        if (sel == 4) begin
            case ($urandom_range(0, 3))
                0:       return 32'h0000_0000;
                1:       return 32'hFFFF_FFFF;
                2:       return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        if (sel < 7)
            return 32'($urandom_range(0, 255));
        return $urandom;
    endfunction

    task automatic add_random(input logic [1:0] kind);
        add_req(kind, spqb_pkg::t_tag'($urandom), spqb_pkg::t_tag'($urandom), pick_weight());
    endtask

    task automatic build_stimulus();
        int unsigned sel;
        int steps;
        // Reads of an empty queue and of an idle cursor.
        add_req(spqb_pkg::REQ_POP,    16'h0000, 16'h0000, 32'h0000_0000);
        add_req(spqb_pkg::REQ_BNEXT,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        add_req(spqb_pkg::REQ_BFIRST, 16'h0000, 16'h0000, 32'h0000_0000);
        add_req(spqb_pkg::REQ_PUSH,   16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        add_req(spqb_pkg::REQ_PUSH,   16'h0000, 16'h0000, 32'h0000_0000);
        add_req(spqb_pkg::REQ_PUSH,   16'hAAAA, 16'h5555, 32'h0000_0005);
        // An equal weight goes ahead of the one already stored.
        add_req(spqb_pkg::REQ_PUSH,   16'h5555, 16'hAAAA, 32'h0000_0005);
        add_req(spqb_pkg::REQ_BFIRST, 16'h0000, 16'h0000, 32'h0000_0000);
        add_req(spqb_pkg::REQ_BNEXT,  16'h0000, 16'h0000, 32'h0000_0000);
        // One push lands behind the cursor, one ahead of it.
        add_req(spqb_pkg::REQ_PUSH,   16'h1234, 16'h4321, 32'h0000_0001);
        add_req(spqb_pkg::REQ_PUSH,   16'h8001, 16'h0180, 32'h0000_0007);
        add_req(spqb_pkg::REQ_BNEXT,  16'h0000, 16'h0000, 32'h0000_0000);
        add_req(spqb_pkg::REQ_BNEXT,  16'h0000, 16'h0000, 32'h0000_0000);
        add_req(spqb_pkg::REQ_BNEXT,  16'h0000, 16'h0000, 32'h0000_0000);
        add_req(spqb_pkg::REQ_BNEXT,  16'h0000, 16'h0000, 32'h0000_0000);
        // A cursor past the tail does not see a later push.
        add_req(spqb_pkg::REQ_PUSH,   16'h7FFF, 16'h7FFF, 32'h0000_0003);
        add_req(spqb_pkg::REQ_BNEXT,  16'h0000, 16'h0000, 32'h0000_0000);
        // Pops walk the head into the cursor, then pop the entry under it.
        add_req(spqb_pkg::REQ_BFIRST, 16'h0000, 16'h0000, 32'h0000_0000);
        add_req(spqb_pkg::REQ_POP,    16'h0000, 16'h0000, 32'h0000_0000);
        add_req(spqb_pkg::REQ_POP,    16'h0000, 16'h0000, 32'h0000_0000);
        add_req(spqb_pkg::REQ_BNEXT,  16'h0000, 16'h0000, 32'h0000_0000);
        add_req(spqb_pkg::REQ_PUSH,   16'h0001, 16'h8000, 32'h8000_0000);
        add_req(spqb_pkg::REQ_PUSH,   16'h8000, 16'h0001, 32'h7FFF_FFFF);

        while (pending_reqs.size() < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
                while (gen_depth < QUEUE_DEPTH)
                    add_random(spqb_pkg::REQ_PUSH);
                repeat ($urandom_range(1, 4)) add_random(spqb_pkg::REQ_PUSH);
            end else if (sel < 35) begin
                while (gen_depth > 0)
                    add_random(spqb_pkg::REQ_POP);
                repeat ($urandom_range(1, 2)) add_random(spqb_pkg::REQ_POP);
            end else if (sel < 65) begin
                add_random(spqb_pkg::REQ_BFIRST);
                steps = $urandom_range(1, 70);
                repeat (steps) begin
                    case ($urandom_range(0, 9))
                        0:       add_random(spqb_pkg::REQ_PUSH);
                        1:       add_random(spqb_pkg::REQ_POP);
                        default: add_random(spqb_pkg::REQ_BNEXT);
                    endcase
                end
            end else begin
                repeat ($urandom_range(5, 30)) add_random(2'($urandom_range(0, 3)));
            end
        end
    endtask

    // Sender: bursts of words with idle gaps, some long stretches unbroken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            burst_left = $urandom_range(1, 16);
            gap_left   = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_results.push_back(apply_request(pending_reqs.pop_front()));
                accepted_count++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (gap_left > 0 || pending_reqs.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    req_if.valid <= 1'b0;
                end else begin
                    req_if.valid        <= 1'b1;
                    req_if.req_type     <= pending_reqs[0].kind;
                    req_if.parent_value <= pending_reqs[0].parent;
                    req_if.slot_index   <= pending_reqs[0].index;
                    req_if.path_weight  <= pending_reqs[0].weight;
                    if (burst_left <= 1) begin
                        if ($urandom_range(0, 3) == 0) begin
                            burst_left = $urandom_range(50, 200);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 16);
                            gap_left   = $urandom_range(1, 6);
                        end
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // Receiver: stalls follow one of four patterns, picked at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle % 64 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0:       rsp_if.ready <= !long_hold;
                1:       rsp_if.ready <= !long_hold && ($urandom_range(0, 1) == 1);
                2:       rsp_if.ready <= !long_hold && (rx_cycle % 4 != 0);
                default: rsp_if.ready <= !long_hold && (rx_cycle % 3 == 0);
            endcase
        end
    end

    // Once the random part is under way, block the output for a long time so
    // that the request side backs up behind it.
    initial begin
        long_hold = 1'b0;
        while (accepted_count < 150)
            @(posedge i_clk);
        long_hold <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++)
            @(posedge i_clk);
        long_hold <= 1'b0;
    end

    task automatic check_field(input string fname, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result word with no request outstanding, expected none, actual %0h",
                         $time, rsp_if.status);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("status",       want.status,   rsp_if.status);
                check_field("out_parent",   want.parent,   rsp_if.out_parent);
                check_field("out_index",    want.index,    rsp_if.out_index);
                check_field("out_weight",   want.weight,   rsp_if.out_weight);
                check_field("queue_empty",  want.is_empty, rsp_if.queue_empty);
                check_field("browse_done",  want.at_end,   rsp_if.browse_done);
                check_field("single_entry", want.single,   rsp_if.single_entry);
                check_field("entry_count",  want.count,    rsp_if.entry_count);
                checked_count++;
            end
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.req_type     = spqb_pkg::REQ_PUSH;
        req_if.parent_value = '0;
        req_if.slot_index   = '0;
        req_if.path_weight  = '0;
        rsp_if.ready        = 1'b0;
        build_stimulus();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_reqs.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d result words for %0d requests: %0d stored pushes,",
                 checked_count, accepted_count, n_stored);
        $display("%0d dropped on full, %0d entries read, %0d empty reads, peak depth %0d of %0d.",
                 n_full_drops, n_reads, n_empty_reads, peak_depth, QUEUE_DEPTH);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
